[hdl/fwpr_pkg.sv]
// ----------------------------------------------------------------------------
// fwpr_pkg: shared types and constants
// Queue depth, element width, command and result transfer types, and the
// control bundle that the top level hands to each storage cell.
// ----------------------------------------------------------------------------
package fwpr_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int SLOT_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_DISCARD = 2'd2,
        OP_QUERY   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_POS_RANGE = 2'd3
    } status_t;

    typedef struct packed {
        opcode_t            opcode;
        logic signed [31:0] value;
        logic [3:0]         position;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] head_value;
        logic               is_empty;
        logic [4:0]         count;
    } result_t;

    // Per-cell control: load the enqueued value, or take the right neighbor.
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

[hdl/fifo_with_positional_remove_top.sv]
// ----------------------------------------------------------------------------
// fifo_with_positional_remove_top: queue with removal at a position
// A bounded FIFO of signed elements held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
// A command transfer is taken at a rising edge where start is high and busy
// is low. The command carries an opcode (enqueue, dequeue, discard at a
// position, or query), a value for enqueue and a position for discard.
// Every command produces exactly one result transfer: done is high for one
// cycle, the cycle after the command was taken, while result holds the
// status, the head value, the empty flag and the element count as they stand
// after the command. The receiver cannot stall, so nothing is held back.
// Throughput is one command per cycle: all cells update in parallel, each
// loading the new value or its right neighbor, so busy never rises.
// Rejected commands (enqueue when full, dequeue or discard when empty,
// discard at a position not below the count) leave the queue unchanged and
// report their status. Reset empties the queue at once; the storage cells
// themselves are not cleared since unfilled cells are never reported.
// ----------------------------------------------------------------------------
module fifo_with_positional_remove_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  fwpr_pkg::cmd_t    cmd,
    output logic              done,
    output fwpr_pkg::result_t result
);

    localparam int DW = fwpr_pkg::DATA_WIDTH;

    logic [fwpr_pkg::CNT_W-1:0]    occ_reg;
    logic [fwpr_pkg::CNT_W-1:0]    occ_next;
    logic                          done_reg;
    logic                          done_next;
    fwpr_pkg::result_t             result_reg;
    fwpr_pkg::result_t             result_next;

    logic                          accept;
    logic                          do_enq;
    logic                          do_drop;
    logic [fwpr_pkg::SLOT_W-1:0]   drop_idx;
    fwpr_pkg::status_t             status;
    logic [DW-1:0]                 head_next;

    fwpr_pkg::cell_ctrl_t          ctrl [fwpr_pkg::DEPTH];
    logic [DW-1:0]                 slot_data [fwpr_pkg::DEPTH];

    // No command ever holds the block back, so busy is tied low.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Decode the command against the current count.
    always_comb
    begin
        do_enq   = 1'b0;
        do_drop  = 1'b0;
        drop_idx = '0;
        status   = fwpr_pkg::ST_OK;
        case (cmd.opcode)
            fwpr_pkg::OP_ENQUEUE:
            begin
                if (occ_reg >= fwpr_pkg::CNT_W'(fwpr_pkg::DEPTH))
                begin
                    status = fwpr_pkg::ST_FULL;
                end
                else
                begin
                    do_enq = accept;
                end
            end
            fwpr_pkg::OP_DEQUEUE:
            begin
                if (occ_reg == '0)
                begin
                    status = fwpr_pkg::ST_EMPTY;
                end
                else
                begin
                    do_drop = accept;
                end
            end
            fwpr_pkg::OP_DISCARD:
            begin
                // The empty check takes precedence over the range check.
                if (occ_reg == '0)
                begin
                    status = fwpr_pkg::ST_EMPTY;
                end
                else if (fwpr_pkg::CNT_W'(cmd.position) >= occ_reg)
                begin
                    status = fwpr_pkg::ST_POS_RANGE;
                end
                else
                begin
                    do_drop  = accept;
                    drop_idx = fwpr_pkg::SLOT_W'(cmd.position);
                end
            end
            fwpr_pkg::OP_QUERY:
            begin
                status = fwpr_pkg::ST_OK;
            end
            default:
            begin
                status = fwpr_pkg::ST_OK;
            end
        endcase
    end

    // Per-cell control: the enqueue lands in the first free cell, and a drop
    // makes every cell from the dropped position onward take its neighbor.
    always_comb
    begin
        for (int i = 0; i < fwpr_pkg::DEPTH; i++)
        begin
            ctrl[i].load  = do_enq && (occ_reg[fwpr_pkg::SLOT_W-1:0] == fwpr_pkg::SLOT_W'(i));
            ctrl[i].shift = do_drop && (fwpr_pkg::SLOT_W'(i) >= drop_idx);
        end
    end

    genvar g;
    generate
        for (g = 0; g < fwpr_pkg::DEPTH; g++)
        begin : g_cell
            logic [DW-1:0] right;
            if (g == fwpr_pkg::DEPTH - 1)
            begin : g_last
                assign right = slot_data[g];
            end
            else
            begin : g_mid
                assign right = slot_data[g+1];
            end

            fwpr_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl[g]),
                .load_data  (cmd.value[DW-1:0]),
                .right_data (right),
                .data       (slot_data[g])
            );
        end
    endgenerate

    // Count and head as they will stand after this command.
    always_comb
    begin
        occ_next = occ_reg;
        if (do_enq)
        begin
            occ_next = occ_reg + fwpr_pkg::CNT_W'(1);
        end
        else if (do_drop)
        begin
            occ_next = occ_reg - fwpr_pkg::CNT_W'(1);
        end

        if (ctrl[0].load)
        begin
            head_next = cmd.value[DW-1:0];
        end
        else if (ctrl[0].shift)
        begin
            head_next = slot_data[1];
        end
        else
        begin
            head_next = slot_data[0];
        end
    end

    always_comb
    begin
        done_next              = accept;
        result_next.status     = status;
        result_next.head_value = (occ_next == '0) ? 32'sd0 : $signed(head_next);
        result_next.is_empty   = (occ_next == '0);
        result_next.count      = occ_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                occ_reg <= occ_next;
            end
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // The count never exceeds the number of cells.
    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= fwpr_pkg::CNT_W'(fwpr_pkg::DEPTH))
        else $error("occupancy exceeds depth");

    // A reported count always matches the live count.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.count == occ_reg && result.is_empty == (occ_reg == '0)))
        else $error("reported count disagrees with occupancy");

    // Every command is followed by a result, and a rejected one leaves the count unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (done && (result.status == fwpr_pkg::ST_OK || occ_reg == $past(occ_reg))))
        else $error("rejected command changed the queue or result missing");

    // An empty queue reports a zero head.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_empty) |-> (result.head_value == 32'sd0))
        else $error("empty queue reported a nonzero head");

endmodule

[hdl/fwpr_cell.sv]
// ----------------------------------------------------------------------------
// fwpr_cell: one queue storage cell
// Holds one element; loads a new value or takes its right neighbor's value.
// ----------------------------------------------------------------------------
module fwpr_cell (
    input  logic                                clk,
    input  fwpr_pkg::cell_ctrl_t                ctrl,
    input  logic [fwpr_pkg::DATA_WIDTH-1:0]     load_data,
    input  logic [fwpr_pkg::DATA_WIDTH-1:0]     right_data,
    output logic [fwpr_pkg::DATA_WIDTH-1:0]     data
);

    logic [fwpr_pkg::DATA_WIDTH-1:0] data_reg;
    logic [fwpr_pkg::DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load)
        begin
            data_next = load_data;
        end
        else if (ctrl.shift)
        begin
            data_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[tb/fifo_with_positional_remove_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_positional_remove_checker: queue report scoreboard
// Keeps a shadow copy of the queue, works out the report of every accepted
// command and compares it field by field with the result transfer that
// follows.
// ----------------------------------------------------------------------------
module fifo_with_positional_remove_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  fwpr_pkg::cmd_t    cmd,
    input  logic              done,
    input  fwpr_pkg::result_t result,
    output int                mismatch_count,
    output int                pending_count,
    output int                compared_count
);

    logic signed [fwpr_pkg::DATA_WIDTH-1:0] shadow_queue[$];
    fwpr_pkg::result_t                      awaited_reports[$];
    int                                     mismatches;
    int                                     compared;

    // Applies one command to the shadow queue and returns the report that the
    // block should give for it.
    function automatic fwpr_pkg::result_t next_queue_report(input fwpr_pkg::cmd_t c);
        fwpr_pkg::result_t r;
        r = '0;
        r.status = fwpr_pkg::ST_OK;
        case (c.opcode)
            fwpr_pkg::OP_ENQUEUE:
            begin
                if (shadow_queue.size() >= fwpr_pkg::DEPTH)
                    r.status = fwpr_pkg::ST_FULL;
                else
                    shadow_queue.push_back(c.value[fwpr_pkg::DATA_WIDTH-1:0]);
            end
            fwpr_pkg::OP_DEQUEUE:
            begin
                if (shadow_queue.size() == 0)
                    r.status = fwpr_pkg::ST_EMPTY;
                else
                    void'(shadow_queue.pop_front());
            end
            fwpr_pkg::OP_DISCARD:
            begin
                if (shadow_queue.size() == 0)
                    r.status = fwpr_pkg::ST_EMPTY;
                else if (int'(c.position) >= shadow_queue.size())
                    r.status = fwpr_pkg::ST_POS_RANGE;
                else
                    shadow_queue.delete(int'(c.position));
            end
            default:
            begin
            end
        endcase
        r.is_empty   = (shadow_queue.size() == 0);
        r.count      = 5'(shadow_queue.size());
        r.head_value = r.is_empty ? 32'sd0 : 32'(shadow_queue[0]);
        return r;
    endfunction

    task automatic log_mismatch(input string what, input fwpr_pkg::result_t want,
                                input fwpr_pkg::result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: expected status=%0d head=%0d empty=%0b count=%0d,",
                     $realtime, what, want.status, want.head_value, want.is_empty,
                     want.count,
                     "  got status=%0d head=%0d empty=%0b count=%0d",
                     got.status, got.head_value, got.is_empty, got.count);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        fwpr_pkg::result_t want;
        if (!rst_n)
        begin
            shadow_queue.delete();
            awaited_reports.delete();
            mismatches      = 0;
            compared        = 0;
            mismatch_count <= 0;
            pending_count  <= 0;
            compared_count <= 0;
        end
        else
        begin
            // A result transfer is checked before this edge's command is
            // predicted, since its report belongs to an earlier command.
            if (done === 1'b1)
            begin
                if (awaited_reports.size() == 0)
                begin
                    log_mismatch("result with no command outstanding", '0, result);
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    compared++;
                    if (result.status !== want.status
                        || result.head_value !== want.head_value
                        || result.is_empty !== want.is_empty
                        || result.count !== want.count)
                        log_mismatch("report mismatch", want, result);
                end
            end
            if (start && !busy)
                awaited_reports.push_back(next_queue_report(cmd));
            mismatch_count <= mismatches;
            pending_count  <= awaited_reports.size();
            compared_count <= compared;
        end
    end

endmodule

[tb/fifo_with_positional_remove_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_positional_remove_top_test: queue with positional remove bench
// Drives a directed command sequence and then phases of random commands into
// the queue, with random sender gaps, while the checker compares every report.
// ----------------------------------------------------------------------------
module fifo_with_positional_remove_top_test;

    // Command mixes for the random phases. Fill phases push the queue up to
    // full so that full rejections and discards deep in the queue happen;
    // drain phases empty it so that empty and range rejections happen.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } mix_t;

    localparam int RANDOM_ITEMS = 800;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    fwpr_pkg::cmd_t    cmd;
    logic              done;
    fwpr_pkg::result_t result;

    int      mismatch_count;
    int      pending_count;
    int      compared_count;
    int      op_tally[4];

    fifo_with_positional_remove_top uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    fifo_with_positional_remove_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .done           (done),
        .result         (result),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .compared_count (compared_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Safety net: a hang of any kind ends the run here, reported as a mismatch.
    initial
    begin
        #2000000;
        $display("fifo_with_positional_remove_top: mismatch");
        $finish;
    end

    function automatic fwpr_pkg::cmd_t mk_cmd(input fwpr_pkg::opcode_t op,
                                              input logic signed [31:0] val,
                                              input logic [3:0] pos);
        fwpr_pkg::cmd_t c;
        c.opcode   = op;
        c.value    = val;
        c.position = pos;
        return c;
    endfunction

    // Random command for a phase. Values now and then take the extremes of
    // the signed range; positions cover the whole 4-bit field, so discards
    // fall both inside and beyond the current count.
    function automatic fwpr_pkg::cmd_t random_cmd(input mix_t mix);
        int                 roll;
        int                 enq_w;
        int                 deq_w;
        int                 disc_w;
        fwpr_pkg::opcode_t  op;
        logic signed [31:0] val;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
            begin
                enq_w  = 70;
                deq_w  = 10;
                disc_w = 15;
            end
            MIX_DRAIN:
            begin
                enq_w  = 15;
                deq_w  = 35;
                disc_w = 40;
            end
            default:
            begin
                enq_w  = 40;
                deq_w  = 20;
                disc_w = 30;
            end
        endcase
        if (roll < enq_w)
            op = fwpr_pkg::OP_ENQUEUE;
        else if (roll < enq_w + deq_w)
            op = fwpr_pkg::OP_DEQUEUE;
        else if (roll < enq_w + deq_w + disc_w)
            op = fwpr_pkg::OP_DISCARD;
        else
            op = fwpr_pkg::OP_QUERY;
        case ($urandom_range(0, 15))
            0:       val = 32'sh7FFF_FFFF;
            1:       val = 32'sh8000_0000;
            2:       val = 32'sd0;
            3:       val = -32'sd1;
            default: val = $urandom;
        endcase
        return mk_cmd(op, val, 4'($urandom_range(0, 15)));
    endfunction

    // One command transfer. The command is presented at a clock edge and held
    // until an edge where busy is low takes it. Afterwards the sender may go
    // quiet, so gaps land after every kind of command.
    task automatic transfer_cmd(input fwpr_pkg::cmd_t c, input bit allow_idle);
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        op_tally[c.opcode]++;
        if (allow_idle && $urandom_range(0, 99) < 38)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3))
                @(posedge clk);
        end
    endtask

    // Holds the sender off until the checker has no report outstanding, or until
    // a guard count runs out. The checker's counts are registered, so the value
    // read just after an edge already includes the command taken at the edge before.
    task automatic wait_for_results();
        int guard;
        guard = 0;
        start <= 1'b0;
        do
        begin
            @(posedge clk);
            guard++;
        end
        while (pending_count != 0 && guard < 1000);
    endtask

    initial
    begin
        mix_t mix;
        int   phase_len;
        int   n;
        bit   quiet;

        // Every input is known from time zero, while reset is held low.
        rst_n = 1'b0;
        start = 1'b0;
        cmd   = '0;
        for (int i = 0; i < 4; i++)
            op_tally[i] = 0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Commands on the empty queue come first: a query,
        // then dequeue and discard, both rejected as empty (the empty check
        // wins over a position that is also out of range).
        transfer_cmd(mk_cmd(fwpr_pkg::OP_QUERY, 32'sd0, 4'd0), 1'b1);
        transfer_cmd(mk_cmd(fwpr_pkg::OP_DEQUEUE, 32'sd0, 4'd0), 1'b1);
        transfer_cmd(mk_cmd(fwpr_pkg::OP_DISCARD, 32'sd0, 4'd5), 1'b1);
        // The extremes of the value field.
        transfer_cmd(mk_cmd(fwpr_pkg::OP_ENQUEUE, 32'sh7FFF_FFFF, 4'd15), 1'b1);
        transfer_cmd(mk_cmd(fwpr_pkg::OP_ENQUEUE, 32'sh8000_0000, 4'd0), 1'b1);
        transfer_cmd(mk_cmd(fwpr_pkg::OP_ENQUEUE, 32'sd0, 4'd0), 1'b1);
        transfer_cmd(mk_cmd(fwpr_pkg::OP_ENQUEUE, -32'sd1, 4'd0), 1'b1);
        // Position equal to the count is out of range; then the tail, the
        // head and a plain dequeue are removed in turn.
        transfer_cmd(mk_cmd(fwpr_pkg::OP_DISCARD, 32'sd0, 4'd4), 1'b1);
        transfer_cmd(mk_cmd(fwpr_pkg::OP_DISCARD, 32'sd0, 4'd3), 1'b1);
        transfer_cmd(mk_cmd(fwpr_pkg::OP_DISCARD, 32'sd0, 4'd0), 1'b1);
        transfer_cmd(mk_cmd(fwpr_pkg::OP_DEQUEUE, 32'sd0, 4'd0), 1'b1);
        // Fill to the last slot, enqueue into the full queue, then drop the
        // tail of a full queue at the highest position and report.
        for (int i = 0; i < 15; i++)
            transfer_cmd(mk_cmd(fwpr_pkg::OP_ENQUEUE, $urandom, 4'(i)), 1'b1);
        transfer_cmd(mk_cmd(fwpr_pkg::OP_ENQUEUE, 32'sh1234_5678, 4'd0), 1'b1);
        transfer_cmd(mk_cmd(fwpr_pkg::OP_DISCARD, 32'sd0, 4'd15), 1'b1);
        transfer_cmd(mk_cmd(fwpr_pkg::OP_QUERY, 32'sd0, 4'd0), 1'b1);

        // Random part: phases of one mix each. One stretch runs with the
        // sender never idle, and once mid-run the sender waits for every
        // outstanding report before going on.
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            mix       = mix_t'($urandom_range(0, 2));
            phase_len = $urandom_range(20, 60);
            for (int k = 0; k < phase_len && n < RANDOM_ITEMS; k++)
            begin
                quiet = (n >= 300 && n < 450);
                transfer_cmd(random_cmd(mix), !quiet);
                if (n == 520)
                    wait_for_results();
                n++;
            end
        end

        // Let the last reports arrive, then wait on to catch any stray result
        // transfer.
        wait_for_results();
        repeat (4)
            @(posedge clk);

        $display("Sent %0d enqueue, %0d dequeue, %0d discard and %0d query commands;",
                 op_tally[fwpr_pkg::OP_ENQUEUE], op_tally[fwpr_pkg::OP_DEQUEUE],
                 op_tally[fwpr_pkg::OP_DISCARD], op_tally[fwpr_pkg::OP_QUERY]);
        $display("%0d reports compared, %0d outstanding at the end.",
                 compared_count, pending_count);
        if (mismatch_count == 0 && pending_count == 0)
            $display("fifo_with_positional_remove_top: match");
        else
            $display("fifo_with_positional_remove_top: mismatch");
        $finish;
    end

endmodule
